// ===== rtl/itr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interval timer register package
// Request and response types, command codes and register map constants.
// ----------------------------------------------------------------------------
package itr_pkg;

  localparam int unsigned HalfWidth  = 16;
  localparam int unsigned CountWidth = 33;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    REG_STATUS    = 3'd0,
    REG_CONTROL   = 3'd1,
    REG_PERIOD_LO = 3'd2,
    REG_PERIOD_HI = 3'd3,
    REG_SNAP_LO   = 3'd4,
    REG_SNAP_HI   = 3'd5,
    REG_UNUSED_6  = 3'd6,
    REG_UNUSED_7  = 3'd7
  } reg_idx_t;

  // Bit positions in the status and control registers.
  localparam int unsigned StTimeoutBit = 0;
  localparam int unsigned StRunningBit = 1;
  localparam int unsigned CtItoBit     = 0;
  localparam int unsigned CtContBit    = 1;
  localparam int unsigned CtStartBit   = 2;
  localparam int unsigned CtStopBit    = 3;

  localparam logic [CountWidth-1:0] CountResetValue = 33'h0_FFFF_FFFF;

  typedef struct packed {
    logic [1:0]           cmd;
    logic [2:0]           reg_index;
    logic [HalfWidth-1:0] write_data;
  } req_t;

  typedef struct packed {
    logic [HalfWidth-1:0] read_data;
    logic                 irq_line;
  } rsp_t;

endpackage

// ===== rtl/itr_rsp_buffer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interval timer response buffer
// Two-entry output queue that lets the request side keep moving while a
// response waits on the consumer.
// ----------------------------------------------------------------------------
module itr_rsp_buffer (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  itr_pkg::rsp_t push_data,
  output logic         not_full,
  output logic         rsp_valid,
  input  logic         rsp_ready,
  output itr_pkg::rsp_t rsp
);

  logic [1:0]    count;
  itr_pkg::rsp_t entry0;
  itr_pkg::rsp_t entry1;
  logic          pop;

  assign not_full  = (count != 2'd2);
  assign rsp_valid = (count != 2'd0);
  assign rsp       = entry0;
  assign pop       = rsp_valid && rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (push && !pop) begin
      count <= count + 2'd1;
    end else if (pop && !push) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !pop) begin
      if (count == 2'd0) begin
        entry0 <= push_data;
      end else begin
        entry1 <= push_data;
      end
    end else if (pop && !push) begin
      entry0 <= entry1;
    end else if (pop && push) begin
      // With one entry held the new transfer takes the head directly.
      if (count == 2'd1) begin
        entry0 <= push_data;
      end else begin
        entry0 <= entry1;
        entry1 <= push_data;
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("response buffer count out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> not_full)
    else $error("push into a full response buffer");

  a_push_empty_valid: assert property (@(posedge clk) disable iff (rst)
      (push && count == 2'd0) |=> rsp_valid)
    else $error("pushed response not presented");

  a_last_pop_empty: assert property (@(posedge clk) disable iff (rst)
      (pop && !push && count == 2'd1) |=> !rsp_valid)
    else $error("buffer not empty after last pop");

endmodule

// ===== rtl/interval_timer_registers.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interval timer registers
// 33-bit down counter behind six 16-bit word registers, driven by read,
// write and tick requests.
// ----------------------------------------------------------------------------
// One request is taken every clock cycle while the output buffer has room. Its
// effect on the timer state is applied at the transfer, and its single response
// (read data and interrupt level) is registered into a two-entry output buffer,
// so requests keep flowing while one response waits on the consumer and stall
// when two do. Reads return the state as it stood before the request; the
// interrupt level reflects the state after it.
// ----------------------------------------------------------------------------
module interval_timer_registers (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  itr_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output itr_pkg::rsp_t rsp
);

  localparam int unsigned HW = itr_pkg::HalfWidth;
  localparam int unsigned CW = itr_pkg::CountWidth;

  logic          timeout_flag, timeout_flag_next;
  logic          running_flag, running_flag_next;
  logic          irq_enable, irq_enable_next;
  logic          continuous_mode, continuous_mode_next;
  logic [HW-1:0] period_lo, period_lo_next;
  logic [HW-1:0] period_hi, period_hi_next;
  logic [HW-1:0] snap_lo, snap_lo_next;
  logic [HW-1:0] snap_hi, snap_hi_next;
  logic [CW-1:0] down_count, down_count_next;

  logic          accept;
  logic [CW-1:0] reload_cur;
  logic [CW-1:0] reload_new;
  logic [HW-1:0] read_value;
  itr_pkg::rsp_t rsp_new;

  assign accept     = req_valid && req_ready;
  assign reload_cur = {1'b0, period_hi, period_lo} + {{(CW-1){1'b0}}, 1'b1};
  assign reload_new = {1'b0, period_hi_next, period_lo_next} + {{(CW-1){1'b0}}, 1'b1};

  always_comb begin
    read_value = '0;
    unique case (itr_pkg::reg_idx_t'(req.reg_index))
      itr_pkg::REG_STATUS: begin
        read_value[itr_pkg::StTimeoutBit] = timeout_flag;
        read_value[itr_pkg::StRunningBit] = running_flag;
      end
      itr_pkg::REG_CONTROL: begin
        read_value[itr_pkg::CtItoBit]  = irq_enable;
        read_value[itr_pkg::CtContBit] = continuous_mode;
      end
      itr_pkg::REG_PERIOD_LO: read_value = period_lo;
      itr_pkg::REG_PERIOD_HI: read_value = period_hi;
      itr_pkg::REG_SNAP_LO:   read_value = snap_lo;
      itr_pkg::REG_SNAP_HI:   read_value = snap_hi;
      default:                read_value = '0;
    endcase
  end

  always_comb begin
    timeout_flag_next    = timeout_flag;
    running_flag_next    = running_flag;
    irq_enable_next      = irq_enable;
    continuous_mode_next = continuous_mode;
    period_lo_next       = period_lo;
    period_hi_next       = period_hi;
    snap_lo_next         = snap_lo;
    snap_hi_next         = snap_hi;
    down_count_next      = down_count;
    rsp_new.read_data    = '0;

    unique case (itr_pkg::cmd_t'(req.cmd))
      itr_pkg::CMD_READ: begin
        rsp_new.read_data = read_value;
      end
      itr_pkg::CMD_WRITE: begin
        unique case (itr_pkg::reg_idx_t'(req.reg_index))
          itr_pkg::REG_STATUS: timeout_flag_next = 1'b0;
          itr_pkg::REG_CONTROL: begin
            irq_enable_next      = req.write_data[itr_pkg::CtItoBit];
            continuous_mode_next = req.write_data[itr_pkg::CtContBit];
            // Stop wins over a start in the same write.
            running_flag_next = (running_flag || req.write_data[itr_pkg::CtStartBit])
                                && !req.write_data[itr_pkg::CtStopBit];
          end
          itr_pkg::REG_PERIOD_LO, itr_pkg::REG_PERIOD_HI: begin
            if (req.reg_index == itr_pkg::REG_PERIOD_LO) begin
              period_lo_next = req.write_data;
            end else begin
              period_hi_next = req.write_data;
            end
            running_flag_next = 1'b0;
            down_count_next   = reload_new;
          end
          itr_pkg::REG_SNAP_LO, itr_pkg::REG_SNAP_HI: begin
            snap_lo_next = down_count[HW-1:0];
            snap_hi_next = down_count[2*HW-1:HW];
          end
          default: ;
        endcase
      end
      itr_pkg::CMD_TICK: begin
        if (running_flag) begin
          if (down_count <= {{(CW-1){1'b0}}, 1'b1}) begin
            timeout_flag_next = 1'b1;
            down_count_next   = reload_cur;
            if (!continuous_mode) begin
              running_flag_next = 1'b0;
            end
          end else begin
            down_count_next = down_count - {{(CW-1){1'b0}}, 1'b1};
          end
        end
      end
      default: ;
    endcase

    rsp_new.irq_line = timeout_flag_next && irq_enable_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_flag    <= 1'b0;
      running_flag    <= 1'b0;
      irq_enable      <= 1'b0;
      continuous_mode <= 1'b0;
      period_lo       <= '0;
      period_hi       <= '0;
      snap_lo         <= '0;
      snap_hi         <= '0;
      down_count      <= itr_pkg::CountResetValue;
    end else if (accept) begin
      timeout_flag    <= timeout_flag_next;
      running_flag    <= running_flag_next;
      irq_enable      <= irq_enable_next;
      continuous_mode <= continuous_mode_next;
      period_lo       <= period_lo_next;
      period_hi       <= period_hi_next;
      snap_lo         <= snap_lo_next;
      snap_hi         <= snap_hi_next;
      down_count      <= down_count_next;
    end
  end

  itr_rsp_buffer u_rsp_buffer (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (rsp_new),
    .not_full  (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

// ===== dv/interval_timer_registers_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interval timer registers testbench
// A directed table covers reset values, register extremes and the corner cases
// of start, stop, timeout and snapshot. Biased random register traffic
// follows. Every response is checked against a pinned value or a cycle-free
// model of the timer; both handshakes stall at random but in the last phase.
// ----------------------------------------------------------------------------
module interval_timer_registers_tb;

  localparam int unsigned RandomItems = 800;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned HoldCycles  = 60;
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned MaxReports  = 10;

  typedef struct {
    itr_pkg::req_t r;
    bit            pinned;
    itr_pkg::rsp_t value;
  } table_row_t;

  typedef struct {
    bit            pinned;
    itr_pkg::rsp_t value;
  } pinned_rsp_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          req_valid = 1'b0;
  logic          req_ready;
  itr_pkg::req_t req = '0;
  logic          rsp_valid;
  logic          rsp_ready = 1'b0;
  itr_pkg::rsp_t rsp;

  interval_timer_registers dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Timer model state.
  logic                           tm_timeout;
  logic                           tm_running;
  logic                           tm_irq_en;
  logic                           tm_cont;
  logic [itr_pkg::HalfWidth-1:0]  tm_per_lo;
  logic [itr_pkg::HalfWidth-1:0]  tm_per_hi;
  logic [itr_pkg::HalfWidth-1:0]  tm_snap_lo;
  logic [itr_pkg::HalfWidth-1:0]  tm_snap_hi;
  logic [itr_pkg::CountWidth-1:0] tm_count;

  itr_pkg::rsp_t rsp_expected_q[$];
  pinned_rsp_t   pinned_rsp_q[$];
  table_row_t    directed_rows[$];

  int unsigned phase = 0;
  int unsigned mismatches = 0;
  int unsigned checked = 0;
  int unsigned n_reads = 0;
  int unsigned n_ticks = 0;
  int unsigned n_timeouts = 0;
  int unsigned stall_cycles = 0;

  function automatic logic [itr_pkg::CountWidth-1:0] period_reload();
    return {1'b0, tm_per_hi, tm_per_lo} + 33'd1;
  endfunction

  function automatic void timer_reset();
    tm_timeout = 1'b0;
    tm_running = 1'b0;
    tm_irq_en  = 1'b0;
    tm_cont    = 1'b0;
    tm_per_lo  = '0;
    tm_per_hi  = '0;
    tm_snap_lo = '0;
    tm_snap_hi = '0;
    tm_count   = itr_pkg::CountResetValue;
  endfunction

  // Applies one request to the model and returns the response it produces.
  function automatic itr_pkg::rsp_t next_timer_response(itr_pkg::req_t r);
    itr_pkg::rsp_t o;
    o = '0;
    case (itr_pkg::cmd_t'(r.cmd))
      itr_pkg::CMD_READ: begin
        n_reads++;
        case (itr_pkg::reg_idx_t'(r.reg_index))
          itr_pkg::REG_STATUS: begin
            o.read_data[itr_pkg::StTimeoutBit] = tm_timeout;
            o.read_data[itr_pkg::StRunningBit] = tm_running;
          end
          itr_pkg::REG_CONTROL: begin
            o.read_data[itr_pkg::CtItoBit]  = tm_irq_en;
            o.read_data[itr_pkg::CtContBit] = tm_cont;
          end
          itr_pkg::REG_PERIOD_LO: o.read_data = tm_per_lo;
          itr_pkg::REG_PERIOD_HI: o.read_data = tm_per_hi;
          itr_pkg::REG_SNAP_LO:   o.read_data = tm_snap_lo;
          itr_pkg::REG_SNAP_HI:   o.read_data = tm_snap_hi;
          default:                o.read_data = '0;
        endcase
      end
      itr_pkg::CMD_WRITE: begin
        case (itr_pkg::reg_idx_t'(r.reg_index))
          itr_pkg::REG_STATUS: tm_timeout = 1'b0;
          itr_pkg::REG_CONTROL: begin
            tm_irq_en = r.write_data[itr_pkg::CtItoBit];
            tm_cont   = r.write_data[itr_pkg::CtContBit];
            if (r.write_data[itr_pkg::CtStartBit]) tm_running = 1'b1;
            if (r.write_data[itr_pkg::CtStopBit]) tm_running = 1'b0;
          end
          itr_pkg::REG_PERIOD_LO, itr_pkg::REG_PERIOD_HI: begin
            if (itr_pkg::reg_idx_t'(r.reg_index) == itr_pkg::REG_PERIOD_LO)
              tm_per_lo = r.write_data;
            else
              tm_per_hi = r.write_data;
            tm_running = 1'b0;
            tm_count   = period_reload();
          end
          itr_pkg::REG_SNAP_LO, itr_pkg::REG_SNAP_HI: begin
            tm_snap_lo = tm_count[15:0];
            tm_snap_hi = tm_count[31:16];
          end
          default: ;
        endcase
      end
      itr_pkg::CMD_TICK: begin
        n_ticks++;
        if (tm_running) begin
          if (tm_count <= 33'd1) begin
            n_timeouts++;
            tm_timeout = 1'b1;
            tm_count   = period_reload();
            if (!tm_cont) tm_running = 1'b0;
          end else begin
            tm_count = tm_count - 33'd1;
          end
        end
      end
      default: ;
    endcase
    o.irq_line = tm_timeout & tm_irq_en;
    return o;
  endfunction

  function automatic itr_pkg::req_t mk_req(itr_pkg::cmd_t c, itr_pkg::reg_idx_t i,
                                           logic [itr_pkg::HalfWidth-1:0] d);
    itr_pkg::req_t r;
    r.cmd        = c;
    r.reg_index  = i;
    r.write_data = d;
    return r;
  endfunction

  function automatic void add_row(itr_pkg::cmd_t c, itr_pkg::reg_idx_t i,
                                  logic [itr_pkg::HalfWidth-1:0] d, bit pinned,
                                  logic [itr_pkg::HalfWidth-1:0] rd, logic irq);
    table_row_t row;
    row.r               = mk_req(c, i, d);
    row.pinned          = pinned;
    row.value.read_data = rd;
    row.value.irq_line  = irq;
    directed_rows.push_back(row);
  endfunction

  // Mostly small periods, frequent starts and many ticks, so that the counter
  // times out often in both one-shot and continuous mode.
  function automatic itr_pkg::req_t random_timer_req();
    int unsigned pick;
    logic [itr_pkg::HalfWidth-1:0] d;
    itr_pkg::req_t r;
    pick = $urandom_range(0, 99);
    d = 16'($urandom);
    r = mk_req(itr_pkg::CMD_TICK, itr_pkg::reg_idx_t'($urandom_range(0, 7)), d);
    if (pick < 40) begin
      r.cmd = itr_pkg::CMD_TICK;
    end else if (pick < 62) begin
      r.cmd = itr_pkg::CMD_READ;
    end else if (pick < 70) begin
      r.cmd = itr_pkg::CMD_WRITE;
      r.reg_index = itr_pkg::REG_CONTROL;
      if ($urandom_range(0, 9) < 7)
        r.write_data = (d & ~(16'h1 << itr_pkg::CtStopBit)) |
                       (16'h1 << itr_pkg::CtStartBit);
    end else if (pick < 78) begin
      r.cmd = itr_pkg::CMD_WRITE;
      r.reg_index = ($urandom_range(0, 1) == 1) ? itr_pkg::REG_PERIOD_HI
                                                : itr_pkg::REG_PERIOD_LO;
      if ($urandom_range(0, 99) < 85)
        r.write_data = (r.reg_index == itr_pkg::REG_PERIOD_HI) ? 16'h0
                                                               : 16'($urandom_range(0, 12));
    end else if (pick < 86) begin
      r.cmd = itr_pkg::CMD_WRITE;
      r.reg_index = itr_pkg::REG_STATUS;
    end else if (pick < 93) begin
      r.cmd = itr_pkg::CMD_WRITE;
      r.reg_index = ($urandom_range(0, 1) == 1) ? itr_pkg::REG_SNAP_HI
                                                : itr_pkg::REG_SNAP_LO;
    end else if (pick < 97) begin
      r.cmd = itr_pkg::CMD_WRITE;
      r.reg_index = ($urandom_range(0, 1) == 1) ? itr_pkg::REG_UNUSED_7
                                                : itr_pkg::REG_UNUSED_6;
    end else begin
      r.cmd = itr_pkg::CMD_NOP;
    end
    return r;
  endfunction

  function automatic int unsigned send_idle_pct();
    return (phase == 0) ? 26 : (phase == 1) ? 84 : 0;
  endfunction

  function automatic int unsigned recv_idle_pct();
    return (phase == 0) ? 84 : (phase == 1) ? 26 : 0;
  endfunction

  task automatic send_req(itr_pkg::req_t r, bit pinned, itr_pkg::rsp_t value);
    pinned_rsp_t p;
    p.pinned = pinned;
    p.value  = value;
    pinned_rsp_q.push_back(p);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct()) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (!(req_valid && req_ready));
  endtask

  // Receiver: random backpressure, plus one long hold-off when the last
  // phase begins so the output buffer fills and the request side stalls.
  initial begin
    int unsigned hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && phase == 2) begin
        hold_left = HoldCycles;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        rsp_ready <= 1'b0;
        hold_left--;
      end else begin
        rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct());
      end
    end
  end

  // Transfer monitor: predicts on each request transfer, checks each response
  // transfer, and watches for a stalled run.
  always @(posedge clk) begin
    pinned_rsp_t p;
    itr_pkg::rsp_t predicted;
    itr_pkg::rsp_t want;
    if (rst) begin
      stall_cycles <= 0;
    end else begin
      if (req_valid && req_ready) begin
        p = pinned_rsp_q.pop_front();
        predicted = next_timer_response(req);
        rsp_expected_q.push_back(p.pinned ? p.value : predicted);
      end
      if (rsp_valid && rsp_ready) begin
        checked++;
        if (rsp_expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("ERROR: unexpected response read_data=%h irq=%b", rsp.read_data,
                     rsp.irq_line);
        end else begin
          want = rsp_expected_q.pop_front();
          if (rsp.read_data !== want.read_data || rsp.irq_line !== want.irq_line) begin
            mismatches++;
            if (mismatches <= MaxReports)
              $display("ERROR: response %0d: read_data exp %h got %h, irq exp %b got %b",
                       checked, want.read_data, rsp.read_data, want.irq_line, rsp.irq_line);
          end
        end
      end
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles + 1 >= StallLimit) begin
        $display("ERROR: no transfer for %0d cycles", StallLimit);
        $display("tb: failure");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    itr_pkg::rsp_t none;
    none = '0;
    timer_reset();

    // Reset values, unused registers and the snapshot of the reset count.
    add_row(itr_pkg::CMD_READ,  itr_pkg::REG_STATUS,    16'h0000, 1, 16'h0000, 1'b0);
    add_row(itr_pkg::CMD_READ,  itr_pkg::REG_CONTROL,   16'hFFFF, 1, 16'h0000, 1'b0);
    add_row(itr_pkg::CMD_TICK,  itr_pkg::REG_UNUSED_7,  16'hFFFF, 1, 16'h0000, 1'b0);
    add_row(itr_pkg::CMD_WRITE, itr_pkg::REG_UNUSED_6,  16'hFFFF, 1, 16'h0000, 1'b0);
    add_row(itr_pkg::CMD_READ,  itr_pkg::REG_UNUSED_7,  16'h0000, 1, 16'h0000, 1'b0);
    add_row(itr_pkg::CMD_WRITE, itr_pkg::REG_SNAP_LO,   16'h0000, 1, 16'h0000, 1'b0);
    add_row(itr_pkg::CMD_READ,  itr_pkg::REG_SNAP_HI,   16'h0000, 1, 16'hFFFF, 1'b0);
    // Largest period: the count of 2^32 snapshots as zero.
    add_row(itr_pkg::CMD_WRITE, itr_pkg::REG_PERIOD_LO, 16'hFFFF, 1, 16'h0000, 1'b0);
    add_row(itr_pkg::CMD_WRITE, itr_pkg::REG_PERIOD_HI, 16'hFFFF, 1, 16'h0000, 1'b0);
    add_row(itr_pkg::CMD_WRITE, itr_pkg::REG_SNAP_HI,   16'h1234, 1, 16'h0000, 1'b0);
    add_row(itr_pkg::CMD_READ,  itr_pkg::REG_SNAP_LO,   16'h0000, 1, 16'h0000, 1'b0);
    // Zero period in continuous mode, then start while running and
    // start with stop in one write.
    add_row(itr_pkg::CMD_WRITE, itr_pkg::REG_PERIOD_HI, 16'h0000, 0, 16'h0000, 1'b0);
    add_row(itr_pkg::CMD_WRITE, itr_pkg::REG_PERIOD_LO, 16'h0000, 0, 16'h0000, 1'b0);
    add_row(itr_pkg::CMD_WRITE, itr_pkg::REG_CONTROL,   16'h0007, 0, 16'h0000, 1'b0);
    add_row(itr_pkg::CMD_TICK,  itr_pkg::REG_STATUS,    16'h0000, 0, 16'h0000, 1'b0);
    add_row(itr_pkg::CMD_READ,  itr_pkg::REG_STATUS,    16'h0000, 0, 16'h0000, 1'b0);
    add_row(itr_pkg::CMD_WRITE, itr_pkg::REG_CONTROL,   16'h0004, 0, 16'h0000, 1'b0);
    add_row(itr_pkg::CMD_WRITE, itr_pkg::REG_CONTROL,   16'h000D, 0, 16'h0000, 1'b0);
    add_row(itr_pkg::CMD_WRITE, itr_pkg::REG_STATUS,    16'hFFFF, 0, 16'h0000, 1'b0);
    add_row(itr_pkg::CMD_WRITE, itr_pkg::REG_CONTROL,   16'hFFF0, 0, 16'h0000, 1'b0);
    add_row(itr_pkg::CMD_NOP,   itr_pkg::REG_SNAP_HI,   16'hFFFF, 1, 16'h0000, 1'b0);
    // One-shot countdown from a period of one.
    add_row(itr_pkg::CMD_WRITE, itr_pkg::REG_PERIOD_LO, 16'h0001, 0, 16'h0000, 1'b0);
    add_row(itr_pkg::CMD_WRITE, itr_pkg::REG_CONTROL,   16'h0005, 0, 16'h0000, 1'b0);
    add_row(itr_pkg::CMD_TICK,  itr_pkg::REG_CONTROL,   16'h5A5A, 0, 16'h0000, 1'b0);
    add_row(itr_pkg::CMD_TICK,  itr_pkg::REG_PERIOD_HI, 16'hA5A5, 0, 16'h0000, 1'b0);
    add_row(itr_pkg::CMD_READ,  itr_pkg::REG_STATUS,    16'h0000, 0, 16'h0000, 1'b0);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_req(directed_rows[i].r, directed_rows[i].pinned, directed_rows[i].value);

    for (int unsigned n = 0; n < RandomItems; n++) begin
      if (n == RandomItems / 3) phase = 1;
      if (n == 2 * RandomItems / 3) phase = 2;
      send_req(random_timer_req(), 1'b0, none);
    end
    @(negedge clk);
    req_valid <= 1'b0;

    while (rsp_expected_q.size() > 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (rsp_expected_q.size() > 0) begin
      mismatches++;
      $display("ERROR: %0d responses never arrived", rsp_expected_q.size());
    end
    $display("Checked %0d responses over %0d directed and %0d random requests.",
             checked, directed_rows.size(), RandomItems);
    $display("Covered %0d reads, %0d ticks, %0d timeouts; %0d mismatches.",
             n_reads, n_ticks, n_timeouts, mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
